// ===== hdl/mmsm_pkg.sv =====
// ============================================================================
// mmsm_pkg: shared types and constants of the median/mean smoother
// Sample format, result queue sizing and the divide-by-three helper.
// ============================================================================
package mmsm_pkg;

    localparam int unsigned SAMPLE_WIDTH = 16;
    localparam int unsigned DATA_WIDTH   = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int unsigned SUM_WIDTH    = SAMPLE_WIDTH + 2;
    localparam int unsigned MAG_WIDTH    = SAMPLE_WIDTH + 1;
    localparam int unsigned DIV_SHIFT    = SAMPLE_WIDTH + 3;

    // ceil(2^DIV_SHIFT / 3): exact for every magnitude below 2^(DIV_SHIFT-1)
    localparam logic [63:0]          DIV3_FULL = ((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3;
    localparam logic [DIV_SHIFT-1:0] DIV3_MULT = DIV3_FULL[DIV_SHIFT-1:0];

    localparam int unsigned MAX_PUSH     = 3;
    localparam int unsigned PUSH_CNT_W   = 2;
    localparam int unsigned Q_DEPTH      = 8;
    localparam int unsigned Q_PTR_W      = 3;
    localparam int unsigned Q_LVL_W      = 4;
    localparam int unsigned Q_ROOM_LIMIT = Q_DEPTH - MAX_PUSH;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [SUM_WIDTH-1:0]    t_sum;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] smoothed;
        logic                    last_out;
    } t_result;

    typedef struct packed {
        logic [PUSH_CNT_W-1:0]  count;
        t_result [MAX_PUSH-1:0] item;
    } t_push;

    typedef struct packed {
        logic               room;
        logic [Q_LVL_W-1:0] level;
    } t_q_status;

    // Signed divide by three, truncated toward zero.
    function automatic logic [SAMPLE_WIDTH-1:0] div3(input t_sum sum);
        logic                              neg;
        logic [SUM_WIDTH-1:0]              mag_full;
        logic [MAG_WIDTH-1:0]              mag;
        logic [MAG_WIDTH+DIV_SHIFT-1:0]    prod;
        logic [SAMPLE_WIDTH-1:0]           quo;
        neg      = sum[SUM_WIDTH-1];
        mag_full = neg ? SUM_WIDTH'(-sum) : SUM_WIDTH'(sum);
        mag      = mag_full[MAG_WIDTH-1:0];
        prod     = {{DIV_SHIFT{1'b0}}, mag} * {{MAG_WIDTH{1'b0}}, DIV3_MULT};
        quo      = prod[DIV_SHIFT+SAMPLE_WIDTH-1:DIV_SHIFT];
        return neg ? (~quo + 1'b1) : quo;
    endfunction

endpackage

// ===== hdl/mmsm_outq.sv =====
// ============================================================================
// mmsm_outq: result queue
// Takes up to three results per cycle, hands out one per cycle while popped, in order.
// ============================================================================
module mmsm_outq import mmsm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  logic      i_pop,
    output logic      o_valid,
    output t_result   o_item,
    output t_q_status o_status
);

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_LVL_W-1:0]   r_level;
    logic [Q_LVL_W-1:0]   n_level;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (PUSH_CNT_W'(k) < i_push.count) begin
                r_mem[r_wr + Q_PTR_W'(k)] <= i_push.item[k];
            end
        end
    end

    assign n_level = r_level + Q_LVL_W'(i_push.count) - Q_LVL_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= r_wr + Q_PTR_W'(i_push.count);
            r_rd    <= r_rd + Q_PTR_W'(i_pop);
            r_level <= n_level;
        end
    end

    assign o_valid         = (r_level != '0);
    assign o_item          = r_mem[r_rd];
    assign o_status.room   = (r_level <= Q_LVL_W'(Q_ROOM_LIMIT));
    assign o_status.level  = r_level;

endmodule

// ===== hdl/median3_then_mean3_smoother_core.sv =====
// ============================================================================
// median3_then_mean3_smoother_core: 3-tap median then 3-tap mean smoother
// Filters blocks of signed samples framed by tlast, one per clock while ready.
// ============================================================================
// One sample is accepted per clock while s_axis_tready is high. Each sample
// goes through a 3-tap median and the medians through a 3-tap mean (sum / 3,
// truncated toward zero), with the edge value repeated at both ends of a
// block. The first two samples of a block give no result (a one-sample block
// returns its sample); every later sample gives one, and the sample marked
// tlast adds the two flush results, the final one marked tlast. All work for
// a request happens in the cycle it is accepted; its results are written
// into an eight-entry result queue and show on the master side from the next
// cycle, one per clock while taken. s_axis_tready is high while that queue
// has room for three results. A block yields as many results as it has
// samples, so with the master side always ready the queue never fills,
// block-end flushes included, and a continuous stream runs at one sample
// per clock; the sample side stalls only while the master side is held off.
// ============================================================================
module median3_then_mean3_smoother_core import mmsm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_WIDTH-1:0] s_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample
    input  logic                  s_axis_tlast,   // last
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_WIDTH-1:0] m_axis_tdata,   // [SAMPLE_WIDTH-1:0] smoothed
    output logic                  m_axis_tlast    // last_out
);

    typedef enum logic [1:0] {
        FILL_EMPTY,
        FILL_ONE,
        FILL_FULL
    } t_fill;

    // Median of three, signed.
    function automatic t_sample med3(input t_sample a, input t_sample b, input t_sample c);
        t_sample lo;
        t_sample hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) begin
            return lo;
        end else if (c >= hi) begin
            return hi;
        end
        return c;
    endfunction

    t_fill     r_fill;
    t_fill     n_fill;
    t_sample   r_sw0, r_sw1;   // previous two samples, oldest first
    t_sample   r_mw0, r_mw1;   // previous two medians, oldest first
    t_sample   n_sw0, n_sw1, n_mw0, n_mw1;

    logic      s_acc;
    t_sample   x;
    t_sample   med;
    t_sum      sum_a, sum_b, sum_c;
    t_push     push;
    t_result   q_item;
    t_q_status q_status;

    assign s_acc = s_axis_tvalid & s_axis_tready;
    assign x     = t_sample'(s_axis_tdata[SAMPLE_WIDTH-1:0]);

    // On the second sample both window entries hold the first one, so the
    // median reduces to that sample without a special path.
    assign med   = med3(r_sw0, r_sw1, x);

    // Three candidate mean sums: regular output, first flush, final flush.
    assign sum_a = SUM_WIDTH'(r_mw0) + SUM_WIDTH'(r_mw1) + SUM_WIDTH'(med);
    assign sum_b = SUM_WIDTH'((r_fill == FILL_ONE) ? med : r_mw1)
                 + SUM_WIDTH'(med) + SUM_WIDTH'(x);
    assign sum_c = SUM_WIDTH'(med) + SUM_WIDTH'(x) + SUM_WIDTH'(x);

    always_comb begin
        push       = '0;
        n_fill     = r_fill;
        n_sw0      = r_sw0;
        n_sw1      = r_sw1;
        n_mw0      = r_mw0;
        n_mw1      = r_mw1;
        case (r_fill)
            FILL_EMPTY: begin
                // Seed the sample window; a lone sample passes straight out.
                n_sw0 = x;
                n_sw1 = x;
                push.item[0] = '{smoothed: x, last_out: 1'b1};
                if (s_axis_tlast) begin
                    push.count = PUSH_CNT_W'(1);
                    n_fill     = FILL_EMPTY;
                end else begin
                    n_fill     = FILL_ONE;
                end
            end
            FILL_ONE: begin
                // Seed the median window with the first median.
                n_sw0 = r_sw1;
                n_sw1 = x;
                n_mw0 = med;
                n_mw1 = med;
                push.item[0] = '{smoothed: div3(sum_b), last_out: 1'b0};
                push.item[1] = '{smoothed: div3(sum_c), last_out: 1'b1};
                if (s_axis_tlast) begin
                    push.count = PUSH_CNT_W'(2);
                    n_fill     = FILL_EMPTY;
                end else begin
                    n_fill     = FILL_FULL;
                end
            end
            FILL_FULL: begin
                // Advance both windows and emit one mean; flush on tlast.
                n_sw0 = r_sw1;
                n_sw1 = x;
                n_mw0 = r_mw1;
                n_mw1 = med;
                push.item[0] = '{smoothed: div3(sum_a), last_out: 1'b0};
                push.item[1] = '{smoothed: div3(sum_b), last_out: 1'b0};
                push.item[2] = '{smoothed: div3(sum_c), last_out: 1'b1};
                if (s_axis_tlast) begin
                    push.count = PUSH_CNT_W'(3);
                    n_fill     = FILL_EMPTY;
                end else begin
                    push.count = PUSH_CNT_W'(1);
                end
            end
            default: begin
                n_fill = FILL_EMPTY;
            end
        endcase
        // Drop everything unless the request is actually taken.
        if (!s_acc) begin
            push.count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= FILL_EMPTY;
            r_sw0  <= '0;
            r_sw1  <= '0;
            r_mw0  <= '0;
            r_mw1  <= '0;
        end else if (s_acc) begin
            r_fill <= n_fill;
            r_sw0  <= n_sw0;
            r_sw1  <= n_sw1;
            r_mw0  <= n_mw0;
            r_mw1  <= n_mw1;
        end
    end

    mmsm_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (m_axis_tvalid & m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_item   (q_item),
        .o_status (q_status)
    );

    // Accept only while three results still fit in the queue.
    assign s_axis_tready = q_status.room;
    assign m_axis_tdata  = DATA_WIDTH'(q_item.smoothed);
    assign m_axis_tlast  = q_item.last_out;

    // Queue never fills beyond its depth.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.level <= Q_LVL_W'(Q_DEPTH))
        else $error("result queue level beyond depth");

    // A block end always returns the filter to the start of a block.
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && s_axis_tlast |=> r_fill == FILL_EMPTY)
        else $error("fill state not cleared after last sample");

    // A block end always leaves at least one result waiting.
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && s_axis_tlast |=> m_axis_tvalid)
        else $error("no result after last sample");

    // The first sample of a block that is not its last causes no result.
    a_first_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && !s_axis_tlast && r_fill == FILL_EMPTY
        |=> q_status.level == $past(q_status.level)
                              - Q_LVL_W'($past(m_axis_tvalid & m_axis_tready)))
        else $error("result queued for first sample of a block");

endmodule
